[rtl/core/osd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types and constants of the overlap pair sort and dedup block.
// ----------------------------------------------------------------------------
package osd_pkg;

	// Width of the ID fields on the ports
	localparam int unsigned FIELD_W = 10;

	// Parameter defaults
	localparam int unsigned MAX_PAIRS_DEF = 64;
	localparam int unsigned ID_BITS_DEF   = 10;

	typedef enum logic [0:0] {
		OP_ADD   = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// Control from the sequencer to the minimum scan unit
	typedef struct packed {
		logic start;
		logic has_bound;
	} scan_ctl_t;

	// Status from the minimum scan unit
	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

[rtl/core/osd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module osd_ram #(
	parameter int unsigned WIDTH = 20,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/osd_min_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_min_scan
// Sweep the pair store once and find the smallest key, above a bound when one is given.
// ----------------------------------------------------------------------------
module osd_min_scan #(
	parameter int unsigned MAX_PAIRS = osd_pkg::MAX_PAIRS_DEF,
	parameter int unsigned KEY_W     = 2 * osd_pkg::ID_BITS_DEF,
	localparam int unsigned AW       = $clog2(MAX_PAIRS),
	localparam int unsigned CW       = $clog2(MAX_PAIRS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  osd_pkg::scan_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  logic [KEY_W-1:0]   bound,
	output logic [AW-1:0]      raddr,
	input  logic [KEY_W-1:0]   rdata,
	output osd_pkg::scan_stat_t stat,
	output logic [KEY_W-1:0]   best
);

	logic             busy_q;
	logic [AW-1:0]    addr_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;
	logic             found_q;
	logic             done_q;
	logic [KEY_W-1:0] best_q;
	logic             issue_last;
	logic             qualifies;

	assign raddr      = addr_q;
	assign issue_last = (CW'(addr_q) + CW'(1)) == count;
	assign qualifies  = (!ctl.has_bound || (rdata > bound)) &&
	                    (!found_q || (rdata < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			best_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q      <= 1'b1;
				addr_q      <= '0;
				rd_valid_s1 <= 1'b0;
				found_q     <= 1'b0;
			end else begin
				// issue stage: one read address per cycle
				rd_valid_s1 <= busy_q;
				rd_last_s1  <= issue_last;
				if (busy_q) begin
					if (issue_last) begin
						busy_q <= 1'b0;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				// compare stage: keep the running minimum above the bound
				if (rd_valid_s1) begin
					if (qualifies) begin
						found_q <= 1'b1;
						best_q  <= rdata;
					end
					done_q <= rd_last_s1;
				end
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign best       = best_q;

endmodule

[rtl/core/overlap_pair_sort_dedup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_pair_sort_dedup
// Collect candidate overlap pairs and emit each distinct pair once, sorted.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | opcode, first_id, second_id
//  out     | out_valid/out_ready| low_shape, high_shape, pair_valid,
//          |                    | last_pair, overflowed
//
//  Adds are accepted back to back while idle. A flush with n stored pairs
//  and d distinct pairs takes (d + 1) sweeps of the pair store; each sweep
//  reads the n stored pairs through the single read port.
//  An empty flush gives one result, with pair_valid low and last_pair high.
//  Output stalls hold the sequencer between sweeps; no input is taken
//  during a flush. Reset empties the store and clears the overflow flag.
// ----------------------------------------------------------------------------
module overlap_pair_sort_dedup #(
	parameter int unsigned MAX_PAIRS = osd_pkg::MAX_PAIRS_DEF,
	parameter int unsigned ID_BITS   = osd_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [0:0]                   opcode,
	input  logic [osd_pkg::FIELD_W-1:0]  first_id,
	input  logic [osd_pkg::FIELD_W-1:0]  second_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [osd_pkg::FIELD_W-1:0]  low_shape,
	output logic [osd_pkg::FIELD_W-1:0]  high_shape,
	output logic                         pair_valid,
	output logic                         last_pair,
	output logic                         overflowed
);

	localparam int unsigned KEY_W = 2 * ID_BITS;
	localparam int unsigned AW    = $clog2(MAX_PAIRS);
	localparam int unsigned CW    = $clog2(MAX_PAIRS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 count_q;
	logic                          ovf_q;
	logic                          pend_valid_q;
	logic [KEY_W-1:0]              pend_key_q;
	logic [KEY_W-1:0]              next_key_q;
	logic                          emit_pv_q;
	logic                          emit_last_q;
	logic                          out_valid_q;
	logic [osd_pkg::FIELD_W-1:0]   low_q;
	logic [osd_pkg::FIELD_W-1:0]   high_q;
	logic                          pv_q;
	logic                          last_q;
	logic                          ovf_out_q;

	logic [ID_BITS-1:0]            id_x;
	logic [ID_BITS-1:0]            id_y;
	logic [KEY_W-1:0]              new_key;
	logic                          in_fire;
	logic                          is_add;
	logic                          full;
	logic                          ram_we;
	logic                          out_free;
	logic                          emit_fire;
	logic [AW-1:0]                 raddr;
	logic [KEY_W-1:0]              rdata;
	logic [KEY_W-1:0]              best;
	osd_pkg::scan_ctl_t            scan_ctl;
	osd_pkg::scan_stat_t           scan_stat;

	// IDs wrap to ID_BITS before they are stored; store as (smaller, larger)
	assign id_x    = ID_BITS'(first_id);
	assign id_y    = ID_BITS'(second_id);
	assign new_key = (id_x < id_y) ? {id_x, id_y} : {id_y, id_x};

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign is_add    = (opcode == osd_pkg::OP_ADD);
	assign full      = (count_q == CW'(MAX_PAIRS));
	assign ram_we    = in_fire && is_add && (id_x != id_y) && !full;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (state_q == S_EMIT) && out_free;

	// Start a sweep on a nonempty flush, after the first minimum is found,
	// and after each pending pair is pushed out.
	assign scan_ctl.start =
		(in_fire && !is_add && (count_q != '0)) ||
		((state_q == S_SCAN) && scan_stat.done && scan_stat.found && !pend_valid_q) ||
		(emit_fire && !emit_last_q);
	// The bound is the last pair found; the first sweep looks for the minimum.
	assign scan_ctl.has_bound =
		pend_valid_q && !((state_q == S_SCAN) && scan_ctl.start);

	osd_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_PAIRS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (new_key),
		.raddr (raddr),
		.rdata (rdata)
	);

	osd_min_scan #(
		.MAX_PAIRS (MAX_PAIRS),
		.KEY_W     (KEY_W)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.count  (count_q),
		.bound  (pend_key_q),
		.raddr  (raddr),
		.rdata  (rdata),
		.stat   (scan_stat),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_key_q   <= '0;
			next_key_q   <= '0;
			emit_pv_q    <= 1'b0;
			emit_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			low_q        <= '0;
			high_q       <= '0;
			pv_q         <= 1'b0;
			last_q       <= 1'b0;
			ovf_out_q    <= 1'b0;
		end else begin
			// drop the result once the consumer takes it
			if (out_valid_q && out_ready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (is_add) begin
							// equal IDs: drop without touching the flag
							if (id_x != id_y) begin
								if (full) begin
									ovf_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
						end else if (count_q == '0) begin
							// empty flush: one invalid result, marked last
							emit_pv_q   <= 1'b0;
							emit_last_q <= 1'b1;
							state_q     <= S_EMIT;
						end else begin
							pend_valid_q <= 1'b0;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						if (scan_stat.found) begin
							if (pend_valid_q) begin
								// a larger pair exists: push the pending one out
								next_key_q  <= best;
								emit_pv_q   <= 1'b1;
								emit_last_q <= 1'b0;
								state_q     <= S_EMIT;
							end else begin
								// first minimum: hold it and sweep again
								pend_key_q   <= best;
								pend_valid_q <= 1'b1;
							end
						end else begin
							// nothing above the pending pair: it is the last
							emit_pv_q   <= 1'b1;
							emit_last_q <= 1'b1;
							state_q     <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pv_q        <= emit_pv_q;
						last_q      <= emit_last_q;
						ovf_out_q   <= ovf_q;
						if (emit_pv_q) begin
							low_q  <= osd_pkg::FIELD_W'(pend_key_q[KEY_W-1:ID_BITS]);
							high_q <= osd_pkg::FIELD_W'(pend_key_q[ID_BITS-1:0]);
						end else begin
							low_q  <= '0;
							high_q <= '0;
						end
						if (emit_last_q) begin
							// flush done: empty the store and clear the flag
							count_q      <= '0;
							ovf_q        <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= S_IDLE;
						end else begin
							pend_key_q <= next_key_q;
							state_q    <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign low_shape  = low_q;
	assign high_shape = high_q;
	assign pair_valid = pv_q;
	assign last_pair  = last_q;
	assign overflowed = ovf_out_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overlap pair sort and dedup block.
// Feeds a table of hand-picked adds and flushes, then random add bursts
// closed by a flush. An in-bench predictor sorts and dedups the same pairs.
// Every emitted result is compared field by field against the table rows
// or the predicted pairs, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned FIELD_W     = osd_pkg::FIELD_W;
	localparam int unsigned MAX_PAIRS   = osd_pkg::MAX_PAIRS_DEF;
	localparam int unsigned ID_BITS     = osd_pkg::ID_BITS_DEF;
	localparam logic [FIELD_W-1:0] ID_MASK =
		(ID_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << ID_BITS) - 1);
	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_ROWS       = 22;

	// One emitted result, laid out in port order
	typedef struct packed {
		logic [FIELD_W-1:0] lo_id;
		logic [FIELD_W-1:0] hi_id;
		logic               has_pair;
		logic               is_last;
		logic               ovf;
	} emit_t;

	// One directed row: the item, and where obvious, its single result
	typedef struct packed {
		osd_pkg::op_t       op;
		logic [FIELD_W-1:0] a_id;
		logic [FIELD_W-1:0] b_id;
		logic               typed;
		emit_t              want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [0:0]         opcode;
	logic [FIELD_W-1:0] first_id;
	logic [FIELD_W-1:0] second_id;
	logic               out_valid;
	logic               out_ready;
	logic [FIELD_W-1:0] low_shape;
	logic [FIELD_W-1:0] high_shape;
	logic               pair_valid;
	logic               last_pair;
	logic               overflowed;

	// Predictor state: held pairs as {low, high}, and the dropped-pair flag
	logic [2*FIELD_W-1:0] held_pairs[$];
	logic                 dropped_flag;

	// Results still owed by the block, oldest first
	emit_t expected_emits[$];

	int err_count;
	int cycle_count;
	int items_sent;
	int flush_count;
	int overflow_flushes;
	int results_checked;
	int send_burst;
	int recv_burst;

	// Directed rows. Extremes, equal IDs, reversed duplicates, alternating bit
	// patterns, empty flushes and flushes that carry junk IDs.
	stim_row_t directed_rows [N_ROWS] = '{
		'{osd_pkg::OP_FLUSH, 10'd0,    10'd0,    1'b1, '{10'd0, 10'd0,    1'b0, 1'b1, 1'b0}},
		'{osd_pkg::OP_ADD,   10'd5,    10'd5,    1'b0, '0},
		'{osd_pkg::OP_FLUSH, 10'd1023, 10'd0,    1'b1, '{10'd0, 10'd0,    1'b0, 1'b1, 1'b0}},
		'{osd_pkg::OP_ADD,   10'd1023, 10'd0,    1'b0, '0},
		'{osd_pkg::OP_FLUSH, 10'd0,    10'd0,    1'b1, '{10'd0, 10'd1023, 1'b1, 1'b1, 1'b0}},
		'{osd_pkg::OP_ADD,   10'd0,    10'd1,    1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd1022, 10'd1023, 1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd7,    10'd3,    1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd3,    10'd7,    1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd1023, 10'd1022, 1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd0,    10'd1,    1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd3,    10'd1000, 1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd3,    10'd6,    1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd1023, 10'd1023, 1'b0, '0},
		'{osd_pkg::OP_FLUSH, 10'd512,  10'd511,  1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd682,  10'd341,  1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd341,  10'd682,  1'b0, '0},
		'{osd_pkg::OP_FLUSH, 10'd1023, 10'd1023, 1'b1, '{10'd341, 10'd682, 1'b1, 1'b1, 1'b0}},
		'{osd_pkg::OP_FLUSH, 10'd682,  10'd341,  1'b1, '{10'd0, 10'd0,    1'b0, 1'b1, 1'b0}},
		'{osd_pkg::OP_ADD,   10'd0,    10'd1023, 1'b0, '0},
		'{osd_pkg::OP_ADD,   10'd1022, 10'd0,    1'b0, '0},
		'{osd_pkg::OP_FLUSH, 10'd0,    10'd0,    1'b0, '0}
	};

	overlap_pair_sort_dedup #(
		.MAX_PAIRS(MAX_PAIRS),
		.ID_BITS  (ID_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.first_id  (first_id),
		.second_id (second_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.low_shape (low_shape),
		.high_shape(high_shape),
		.pair_valid(pair_valid),
		.last_pair (last_pair),
		.overflowed(overflowed)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: give up well past the slowest legal run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d results still owed",
			$time, cycle_count, expected_emits.size());
		$display("tb: errors");
		$finish;
	end

	// Advance the predictor by one accepted item. Adds fold the pair into the
	// held list; a flush sorts, drops repeats, marks the final result and
	// empties the list. With queue_results low, only the state moves.
	task automatic predict_item(input osd_pkg::op_t op, input logic [FIELD_W-1:0] a_id,
			input logic [FIELD_W-1:0] b_id, input bit queue_results);
		logic [FIELD_W-1:0]   x;
		logic [FIELD_W-1:0]   y;
		logic [2*FIELD_W-1:0] key;
		emit_t                run_q[$];
		int                   j;
		if (op == osd_pkg::OP_ADD) begin
			x = a_id & ID_MASK;
			y = b_id & ID_MASK;
			if (x != y) begin
				if (held_pairs.size() >= MAX_PAIRS)
					dropped_flag = 1'b1;
				else
					held_pairs.push_back((x < y) ? {x, y} : {y, x});
			end
		end else begin
			flush_count++;
			if (dropped_flag)
				overflow_flushes++;
			if (held_pairs.size() == 0) begin
				run_q.push_back('{'0, '0, 1'b0, 1'b1, dropped_flag});
			end else begin
				// insertion sort on {low, high}, which orders by low then high
				for (int i = 1; i < held_pairs.size(); i++) begin
					key = held_pairs[i];
					j = i;
					while (j > 0 && held_pairs[j-1] > key) begin
						held_pairs[j] = held_pairs[j-1];
						j--;
					end
					held_pairs[j] = key;
				end
				for (int i = 0; i < held_pairs.size(); i++) begin
					if (i == 0 || held_pairs[i] != held_pairs[i-1])
						run_q.push_back('{held_pairs[i][2*FIELD_W-1:FIELD_W],
							held_pairs[i][FIELD_W-1:0], 1'b1, 1'b0, dropped_flag});
				end
				run_q[run_q.size()-1].is_last = 1'b1;
			end
			held_pairs.delete();
			dropped_flag = 1'b0;
			if (queue_results) begin
				foreach (run_q[k])
					expected_emits.push_back(run_q[k]);
			end
		end
	endtask

	// Present one item and hold it until the block takes it. The idle gap is
	// drawn per item; bursts of back-to-back items keep valid high throughout.
	task automatic send_item(input osd_pkg::op_t op, input logic [FIELD_W-1:0] a_id,
			input logic [FIELD_W-1:0] b_id, input bit typed, input emit_t want);
		int gap;
		if (send_burst > 0) begin
			send_burst--;
			gap = 0;
		end else if ($urandom_range(0, 9) == 0) begin
			send_burst = $urandom_range(5, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 17);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		first_id  <= a_id;
		second_id <= b_id;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (typed)
			expected_emits.push_back(want);
		predict_item(op, a_id, b_id, !typed);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Receiver: stall at random, then take one result and check it
	initial begin
		int    stall;
		emit_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (recv_burst > 0) begin
				recv_burst--;
				stall = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				recv_burst = $urandom_range(5, 40);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 17);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_emits.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none,", $time);
				$display("  got lo=%0d hi=%0d v=%0b l=%0b o=%0b",
					low_shape, high_shape, pair_valid, last_pair, overflowed);
			end else begin
				want = expected_emits.pop_front();
				results_checked++;
				check_field("low_shape",  want.lo_id,    low_shape);
				check_field("high_shape", want.hi_id,    high_shape);
				check_field("pair_valid", want.has_pair, pair_valid);
				check_field("last_pair",  want.is_last,  last_pair);
				check_field("overflowed", want.ovf,      overflowed);
			end
		end
	end

	// Main sequence
	initial begin
		int                 rand_items;
		int                 n_adds;
		int                 span;
		bit                 fill_group;
		logic [FIELD_W-1:0] a_id;
		logic [FIELD_W-1:0] b_id;

		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = osd_pkg::OP_ADD;
		first_id     = '0;
		second_id    = '0;
		out_ready    = 1'b0;
		dropped_flag = 1'b0;
		a_id         = '0;
		b_id         = '0;
		err_count        = 0;
		cycle_count      = 0;
		items_sent       = 0;
		flush_count      = 0;
		overflow_flushes = 0;
		results_checked  = 0;
		send_burst       = 0;
		recv_burst       = 0;
		rand_items       = 0;

		// hold reset low, then release it on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_ROWS; r++)
			send_item(directed_rows[r].op, directed_rows[r].a_id, directed_rows[r].b_id,
				directed_rows[r].typed, directed_rows[r].want);

		// Random part: bursts of adds, each closed by a flush. The first burst
		// (and now and then a later one) fills the store and can run past it so
		// that pairs get dropped. Narrow ID spans force many duplicates for the dedup.
		while (rand_items < RANDOM_ITEMS) begin
			fill_group = (rand_items == 0) || ($urandom_range(0, 11) == 0);
			if (fill_group) begin
				n_adds = $urandom_range(MAX_PAIRS, MAX_PAIRS + 8);
				span   = 1023;
			end else begin
				n_adds = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30)
					: $urandom_range(0, 12);
				span   = ($urandom_range(0, 2) == 0) ? 15 : 1023;
			end
			for (int i = 0; i < n_adds; i++) begin
				case ($urandom_range(0, 7))
					0:       a_id = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
					1:       b_id = a_id;
					default: a_id = 10'($urandom_range(0, span));
				endcase
				b_id = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0)
					? 10'd1023 : 10'd0) : 10'($urandom_range(0, span));
				// mostly keep pairs unequal (in fill bursts, for the first MAX_PAIRS
				// adds only) and let an occasional equal pair through as noise
				if (a_id == b_id && (i < MAX_PAIRS || !fill_group)
						&& $urandom_range(0, 15) != 0)
					b_id = a_id ^ 10'd1;
				send_item(osd_pkg::OP_ADD, a_id, b_id, 1'b0, '0);
				if (a_id != b_id)
					rand_items++;
			end
			send_item(osd_pkg::OP_FLUSH, 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)), 1'b0, '0);
			rand_items++;
		end
		in_valid <= 1'b0;

		// drain, then let trailing cycles expose any stray result
		while (expected_emits.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d items, %0d flushes (%0d after dropped pairs)",
			items_sent, flush_count, overflow_flushes);
		$display("%0d results checked, %0d mismatches", results_checked, err_count);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/osd_pkg.sv
rtl/core/osd_ram.sv
rtl/core/osd_min_scan.sv
rtl/core/overlap_pair_sort_dedup.sv
tb/tb.sv
